### hdl/urlpd_pkg.sv
// Shared constants, status codes and character helpers for the URL percent decoder.
`timescale 1ns / 1ps
`default_nettype none

package urlpd_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned StatusW = 3;
    localparam int unsigned UserW   = StatusW + 1;

    localparam logic [ByteW-1:0] ChPlus    = 8'h2B;
    localparam logic [ByteW-1:0] ChPercent = 8'h25;
    localparam logic [ByteW-1:0] ChSpace   = 8'h20;

    localparam logic [ByteW-1:0] MaskLead2 = 8'hE0;
    localparam logic [ByteW-1:0] CodeLead2 = 8'hC0;
    localparam logic [ByteW-1:0] MaskLead3 = 8'hF0;
    localparam logic [ByteW-1:0] CodeLead3 = 8'hE0;
    localparam logic [ByteW-1:0] MaskLead4 = 8'hF8;
    localparam logic [ByteW-1:0] CodeLead4 = 8'hF0;

    typedef enum logic [StatusW-1:0] {
        ST_OK        = 3'd0,
        ST_TRUNC_ESC = 3'd1,
        ST_BAD_HEX   = 3'd2,
        ST_TRUNC_U8  = 3'd3,
        ST_NO_PCT    = 3'd4
    } t_status;

    // Bit 4 set means the character is not a hex digit.
    function automatic logic [4:0] hex_val(input logic [ByteW-1:0] c);
        logic [4:0] v;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            v = {1'b0, c[3:0] + 4'd9};
        end else begin
            v = 5'h10;
        end
        return v;
    endfunction

    // Continuation bytes that follow a UTF-8 lead byte.
    function automatic logic [1:0] extra_count(input logic [ByteW-1:0] b);
        logic [1:0] n;
        if ((b & MaskLead2) == CodeLead2) begin
            n = 2'd1;
        end else if ((b & MaskLead3) == CodeLead3) begin
            n = 2'd2;
        end else if ((b & MaskLead4) == CodeLead4) begin
            n = 2'd3;
        end else begin
            n = 2'd0;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

### hdl/url_percent_decoder_utf8.sv
// URL percent decoder with UTF-8 continuation checking, stream in and stream out.
//
// Input channel (s_axis): one encoded character per request in tdata, tlast marks
// the final character of a string. Output channel (m_axis): at most one result per
// input request; tdata is the decoded byte (zero when none), tuser carries has_byte
// in bit 0 and the status code in bits 3:1, tlast marks the final result of a
// string (its last byte or an error). After an error the rest of the string is
// dropped without results; the consumer discards that string's partial output.
//
// Each result is registered in the output register, or in the skid register while the
// output register still holds one. Throughput: one character per cycle while s_axis tready
// is high, set by the phase update; the decode state is updated at each accepted request.
// Stall: a two-entry output buffer (result register plus skid register) keeps the
// input side open while one result waits; s_axis tready drops only when both hold
// results, and rises again once the receiver takes one.
// Reset (i_rst_n low, synchronous): the decoder returns to the plain-character
// phase, dropping clears, and both output entries empty.
`timescale 1ns / 1ps
`default_nettype none

module url_percent_decoder_utf8 (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire logic [urlpd_pkg::ByteW-1:0]   i_s_axis_tdata,  // [7:0] ch
    input  wire logic                          i_s_axis_tlast,  // last_char
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    output logic [urlpd_pkg::ByteW-1:0]        o_m_axis_tdata,  // [7:0] out_byte
    output logic [urlpd_pkg::UserW-1:0]        o_m_axis_tuser,  // [0] has_byte, [3:1] status
    output logic                               o_m_axis_tlast   // end_of_string
);
    import urlpd_pkg::*;

    typedef enum logic [1:0] {
        PH_PLAIN = 2'd0,
        PH_HI    = 2'd1,
        PH_LO    = 2'd2,
        PH_PCT   = 2'd3
    } t_phase;

    typedef struct packed {
        logic [ByteW-1:0] data;
        logic             has_byte;
        t_status          status;
        logic             eos;
    } t_result;

    // Decode state
    t_phase     r_phase, n_phase;
    logic [3:0] r_high_nibble, n_high_nibble;
    logic       r_lead_pending, n_lead_pending;
    logic [1:0] r_cont_left, n_cont_left;
    logic       r_dropping, n_dropping;

    // Output buffer
    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;

    logic       in_fire, out_fire;
    logic       res_valid;
    t_result    res;
    logic [4:0] hv;
    logic [ByteW-1:0] byte_val;
    logic [1:0] n_cnt;
    logic       last;

    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;
    assign out_fire        = r_out_valid && i_m_axis_tready;
    assign o_s_axis_tready = !r_skid_valid;
    assign last            = i_s_axis_tlast;
    assign hv              = hex_val(i_s_axis_tdata);
    assign byte_val        = {r_high_nibble, hv[3:0]};

    // Single-pass decode of one character.
    always_comb begin
        n_phase        = r_phase;
        n_high_nibble  = r_high_nibble;
        n_lead_pending = r_lead_pending;
        n_cont_left    = r_cont_left;
        n_dropping     = r_dropping;
        res_valid      = 1'b0;
        res            = '{data: '0, has_byte: 1'b0, status: ST_OK, eos: 1'b0};
        n_cnt          = 2'd0;

        if (r_dropping) begin
            // Discard until the string ends.
            if (last) begin
                n_dropping     = 1'b0;
                n_phase        = PH_PLAIN;
                n_high_nibble  = '0;
                n_lead_pending = 1'b0;
                n_cont_left    = '0;
            end
        end else begin
            case (r_phase)
                PH_PLAIN: begin
                    if (i_s_axis_tdata == ChPercent) begin
                        if (last) begin
                            res_valid  = 1'b1;
                            res.status = ST_TRUNC_ESC;
                        end else begin
                            n_phase        = PH_HI;
                            n_lead_pending = 1'b1;
                        end
                    end else begin
                        res_valid    = 1'b1;
                        res.has_byte = 1'b1;
                        res.eos      = last;
                        res.data     = (i_s_axis_tdata == ChPlus) ? ChSpace : i_s_axis_tdata;
                    end
                end
                PH_HI: begin
                    if (last) begin
                        res_valid  = 1'b1;
                        res.status = r_lead_pending ? ST_TRUNC_ESC : ST_TRUNC_U8;
                    end else if (hv[4]) begin
                        res_valid  = 1'b1;
                        res.status = ST_BAD_HEX;
                    end else begin
                        n_high_nibble = hv[3:0];
                        n_phase       = PH_LO;
                    end
                end
                PH_LO: begin
                    if (hv[4]) begin
                        res_valid  = 1'b1;
                        res.status = ST_BAD_HEX;
                    end else begin
                        n_high_nibble  = '0;
                        n_lead_pending = 1'b0;
                        if (r_lead_pending) begin
                            n_cnt = extra_count(byte_val);
                        end else if (r_cont_left != 2'd0) begin
                            n_cnt = r_cont_left - 2'd1;
                        end
                        n_cont_left = n_cnt;
                        res_valid   = 1'b1;
                        if (n_cnt == 2'd0) begin
                            n_phase      = PH_PLAIN;
                            res.has_byte = 1'b1;
                            res.data     = byte_val;
                            res.eos      = last;
                        end else if (last) begin
                            // Sequence cut short: error, byte not delivered.
                            res.status = ST_TRUNC_U8;
                        end else begin
                            n_phase      = PH_PCT;
                            res.has_byte = 1'b1;
                            res.data     = byte_val;
                        end
                    end
                end
                default: begin
                    // Continuation escape must start with '%'.
                    if (i_s_axis_tdata != ChPercent) begin
                        res_valid  = 1'b1;
                        res.status = ST_NO_PCT;
                    end else if (last) begin
                        res_valid  = 1'b1;
                        res.status = ST_TRUNC_U8;
                    end else begin
                        n_phase = PH_HI;
                    end
                end
            endcase

            // Any error ends the string; drop the rest unless it ended here.
            if (res_valid && res.status != ST_OK) begin
                res.eos        = 1'b1;
                n_phase        = PH_PLAIN;
                n_high_nibble  = '0;
                n_lead_pending = 1'b0;
                n_cont_left    = '0;
                n_dropping     = !last;
            end else if (res_valid && res.eos) begin
                n_phase        = PH_PLAIN;
                n_high_nibble  = '0;
                n_lead_pending = 1'b0;
                n_cont_left    = '0;
            end
        end
    end

    // Advance decode state on each accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_PLAIN;
            r_high_nibble  <= '0;
            r_lead_pending <= 1'b0;
            r_cont_left    <= '0;
            r_dropping     <= 1'b0;
        end else if (in_fire) begin
            r_phase        <= n_phase;
            r_high_nibble  <= n_high_nibble;
            r_lead_pending <= n_lead_pending;
            r_cont_left    <= n_cont_left;
            r_dropping     <= n_dropping;
        end
    end

    // Output register with skid: hold a result while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || out_fire) begin
            r_out_valid <= in_fire && res_valid;
        end else if (in_fire && res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (!r_out_valid || out_fire) begin
            r_out <= res;
        end else begin
            r_skid <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out.data;
    assign o_m_axis_tuser  = {r_out.status, r_out.has_byte};
    assign o_m_axis_tlast  = r_out.eos;

endmodule

`default_nettype wire

### tb/url_percent_decoder_utf8_tb.sv
// Self-checking stream testbench for the URL percent decoder with UTF-8 checking.
`timescale 1ns / 1ps

module url_percent_decoder_utf8_tb;

    import urlpd_pkg::*;

    localparam int CHAR_TARGET    = 1450;  // minimum characters offered; the last string is always sent whole
    localparam int DIR_ROWS       = 25;
    localparam int MAX_REPORTS    = 10;
    localparam int WATCHDOG_LIMIT = 4000;  // longest quiet stretch is a receiver hold-off
    localparam int HOLD_CYCLES    = 250;
    localparam int HOLD_AT_A      = 400;
    localparam int HOLD_AT_B      = 1000;
    localparam int DRAIN_CYCLES   = 8;

    // Decoder phases, mirrored on the checker side.
    typedef enum logic [1:0] {
        P_CHAR,
        P_HEX_HI,
        P_HEX_LO,
        P_CONT_PCT
    } t_dec_phase;

    // Receiver stall patterns.
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_BEAT
    } t_rx_mode;

    typedef struct packed {
        logic [7:0] data;
        logic       has;
        t_status    status;
        logic       eos;
    } t_dec_result;

    // One row of the directed table. typed rows carry their result by hand,
    // the others take it from the decode predictor.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       typed;
        logic       want;
        logic [7:0] o_byte;
        logic       o_has;
        t_status    o_st;
        logic       o_eos;
    } t_char_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_s_axis_tvalid = 1'b0;
    logic [7:0] i_s_axis_tdata = '0;
    logic       i_s_axis_tlast = 1'b0;
    logic       i_m_axis_tready = 1'b0;
    logic       o_s_axis_tready;
    logic       o_m_axis_tvalid;
    logic [7:0] o_m_axis_tdata;
    logic [3:0] o_m_axis_tuser;
    logic       o_m_axis_tlast;

    url_percent_decoder_utf8 dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),   // [7:0] ch
        .i_s_axis_tlast  (i_s_axis_tlast),   // last_char
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // [7:0] out_byte
        .o_m_axis_tuser  (o_m_axis_tuser),   // [0] has_byte, [3:1] status
        .o_m_axis_tlast  (o_m_axis_tlast)    // end_of_string
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Decode predictor: own copy of the decoder state, reset values.
    // ------------------------------------------------------------------
    t_dec_phase cur_phase = P_CHAR;
    logic [3:0] hi_digit  = '0;
    logic       lead_esc  = 1'b0;
    logic [1:0] tail_left = '0;
    logic       drop_rest = 1'b0;

    t_dec_result decoded_q[$];   // decoded results still owed by the block

    int fail_count   = 0;
    int results_seen = 0;
    int chars_taken  = 0;
    int live_chars   = 0;
    int strings_sent = 0;
    int quiet_cycles = 0;
    int burst_left   = 0;
    int status_seen[0:4] = '{0, 0, 0, 0, 0};
    logic [7:0] enc_str[$];      // encoded string under construction

    // Hex digit value, or -1 when the character is not a hex digit.
    function automatic int digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return c - "0";
        end else if (c >= "A" && c <= "F") begin
            return c - "A" + 10;
        end else if (c >= "a" && c <= "f") begin
            return c - "a" + 10;
        end
        return -1;
    endfunction

    // Continuation bytes announced by a UTF-8 lead byte.
    function automatic logic [1:0] utf8_tail_len(input logic [7:0] b);
        casez (b)
            8'b110?????: return 2'd1;
            8'b1110????: return 2'd2;
            8'b11110???: return 2'd3;
            default:     return 2'd0;
        endcase
    endfunction

    function automatic void clear_escape();
        cur_phase = P_CHAR;
        hi_digit  = '0;
        lead_esc  = 1'b0;
        tail_left = '0;
    endfunction

    function automatic t_dec_result byte_out(input logic [7:0] b, input logic last);
        t_dec_result r;
        if (last) begin
            clear_escape();
        end
        r.data   = b;
        r.has    = 1'b1;
        r.status = ST_OK;
        r.eos    = last;
        return r;
    endfunction

    // An error closes the string; the rest of it is dropped unless this was its end.
    function automatic t_dec_result fail_out(input t_status st, input logic last);
        t_dec_result r;
        clear_escape();
        drop_rest = !last;
        r.data    = '0;
        r.has     = 1'b0;
        r.status  = st;
        r.eos     = 1'b1;
        return r;
    endfunction

    function automatic void decode_step(input logic [7:0] c, input logic last,
                                        output t_dec_result r, output bit made);
        int         v;
        logic [7:0] b;
        logic [1:0] n;
        made = 1'b0;
        r    = '0;
        if (drop_rest) begin
            if (last) begin
                drop_rest = 1'b0;
                clear_escape();
            end
            return;
        end
        made = 1'b1;
        case (cur_phase)
            P_CHAR: begin
                if (c == ChPlus) begin
                    r = byte_out(ChSpace, last);
                end else if (c == ChPercent) begin
                    if (last) begin
                        r = fail_out(ST_TRUNC_ESC, last);
                    end else begin
                        cur_phase = P_HEX_HI;
                        lead_esc  = 1'b1;
                        made      = 1'b0;
                    end
                end else begin
                    r = byte_out(c, last);
                end
            end
            P_HEX_HI: begin
                v = digit_value(c);
                // the string end wins over a bad digit here
                if (last) begin
                    r = fail_out(lead_esc ? ST_TRUNC_ESC : ST_TRUNC_U8, last);
                end else if (v < 0) begin
                    r = fail_out(ST_BAD_HEX, last);
                end else begin
                    hi_digit  = v[3:0];
                    cur_phase = P_HEX_LO;
                    made      = 1'b0;
                end
            end
            P_HEX_LO: begin
                v = digit_value(c);
                if (v < 0) begin
                    r = fail_out(ST_BAD_HEX, last);
                end else begin
                    b        = {hi_digit, v[3:0]};
                    hi_digit = '0;
                    if (lead_esc) begin
                        lead_esc = 1'b0;
                        n        = utf8_tail_len(b);
                    end else begin
                        n = (tail_left != 2'd0) ? tail_left - 2'd1 : 2'd0;
                    end
                    tail_left = n;
                    if (n == 2'd0) begin
                        cur_phase = P_CHAR;
                        r         = byte_out(b, last);
                    end else if (last) begin
                        r = fail_out(ST_TRUNC_U8, last);
                    end else begin
                        cur_phase = P_CONT_PCT;
                        r.data    = b;
                        r.has     = 1'b1;
                        r.status  = ST_OK;
                        r.eos     = 1'b0;
                    end
                end
            end
            default: begin
                if (c != ChPercent) begin
                    r = fail_out(ST_NO_PCT, last);
                end else if (last) begin
                    r = fail_out(ST_TRUNC_U8, last);
                end else begin
                    cur_phase = P_HEX_HI;
                    made      = 1'b0;
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    function automatic t_char_row pred_row(input logic [7:0] c, input logic last);
        t_char_row r;
        r      = '0;
        r.ch   = c;
        r.last = last;
        return r;
    endfunction

    // Hand-typed result: ok rows carry the byte, error rows close the string.
    function automatic t_char_row chk_row(input logic [7:0] c, input logic last,
                                          input logic [7:0] b, input t_status st);
        t_char_row r;
        r        = pred_row(c, last);
        r.typed  = 1'b1;
        r.want   = 1'b1;
        r.o_byte = b;
        r.o_has  = (st == ST_OK);
        r.o_st   = st;
        r.o_eos  = (st != ST_OK) || last;
        return r;
    endfunction

    function automatic t_char_row quiet_row(input logic [7:0] c, input logic last);
        t_char_row r;
        r       = pred_row(c, last);
        r.typed = 1'b1;
        return r;
    endfunction

    t_char_row dir_rows [DIR_ROWS] = '{
        chk_row(8'h00, 1'b1, 8'h00, ST_OK),          // first string after reset, lowest char
        chk_row(ChPlus, 1'b1, ChSpace, ST_OK),       // plus becomes space
        chk_row(8'hFF, 1'b1, 8'hFF, ST_OK),          // highest char passes through
        chk_row(ChPercent, 1'b1, 8'h00, ST_TRUNC_ESC),
        quiet_row(ChPercent, 1'b0),
        chk_row("G", 1'b1, 8'h00, ST_TRUNC_ESC),     // last first digit, even when not hex
        quiet_row(ChPercent, 1'b0),
        chk_row("z", 1'b0, 8'h00, ST_BAD_HEX),       // error mid-string: tail is dropped
        quiet_row("Q", 1'b1),
        pred_row(ChPercent, 1'b0),                   // two-byte sequence %C3%a9
        pred_row("C", 1'b0),
        pred_row("3", 1'b0),
        pred_row(ChPercent, 1'b0),
        pred_row("a", 1'b0),
        pred_row("9", 1'b1),
        pred_row(ChPercent, 1'b0),                   // three-byte lead, no percent after it
        pred_row("E", 1'b0),
        pred_row("2", 1'b0),
        chk_row("x", 1'b1, 8'h00, ST_NO_PCT),
        pred_row(ChPercent, 1'b0),                   // four-byte lead ends the string
        pred_row("f", 1'b0),
        chk_row("0", 1'b1, 8'h00, ST_TRUNC_U8),
        pred_row(ChPercent, 1'b0),                   // invalid lead goes out as one byte
        pred_row("F", 1'b0),
        pred_row("F", 1'b1)
    };

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Advance the burst; between bursts drop tvalid for a random gap.
    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Offer one character, hold it until taken, then book its expected result.
    task automatic send_request(input t_char_row row);
        t_dec_result res;
        bit          made;
        bit          live;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= row.ch;
        i_s_axis_tlast  <= row.last;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        live = !drop_rest;
        decode_step(row.ch, row.last, res, made);
        if (row.typed) begin
            made       = row.want;
            res.data   = row.o_byte;
            res.has    = row.o_has;
            res.status = row.o_st;
            res.eos    = row.o_eos;
        end
        if (made) begin
            decoded_q = {decoded_q, res};
        end
        chars_taken++;
        if (live) begin
            live_chars++;
        end
        if (row.last) begin
            strings_sent++;
        end
        pace();
    endtask

    function automatic logic [7:0] nibble_char(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return "0" + nib;
        end
        return (($urandom_range(0, 1) != 0) ? "A" : "a") + nib - 4'd10;
    endfunction

    function automatic void push_escape(input logic [7:0] b);
        enc_str = {enc_str, ChPercent};
        enc_str = {enc_str, nibble_char(b[7:4])};
        enc_str = {enc_str, nibble_char(b[3:0])};
    endfunction

    // Build one encoded string: mostly well-formed escapes and UTF-8 sequences
    // with random content, some noise, and now and then a corrupted or cut string.
    task automatic build_string();
        int         n_tok;
        int         kind;
        int         cut;
        logic [7:0] b;
        enc_str.delete();
        n_tok = $urandom_range(1, 6);
        repeat (n_tok) begin
            kind = $urandom_range(0, 99);
            if (kind < 25) begin
                b = 8'($urandom_range(0, 255));
                if (b == ChPercent) begin
                    b = ChPlus;
                end
                enc_str = {enc_str, b};
            end else if (kind < 35) begin
                enc_str = {enc_str, ChPlus};
            end else if (kind < 90) begin
                case ($urandom_range(0, 4))
                    0: b = 8'($urandom_range(0, 8'h7F));
                    1: b = 8'(8'hC0 | $urandom_range(0, 31));
                    2: b = 8'(8'hE0 | $urandom_range(0, 15));
                    3: b = 8'(8'hF0 | $urandom_range(0, 7));
                    default: begin
                        b = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(8'h80, 8'hBF))
                                                        : 8'($urandom_range(8'hF8, 8'hFF));
                    end
                endcase
                push_escape(b);
                repeat (utf8_tail_len(b)) begin
                    push_escape(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                            : 8'(8'h80 | $urandom_range(0, 63)));
                end
            end else begin
                enc_str = {enc_str, 8'($urandom_range(0, 255))};
            end
        end
        case ($urandom_range(0, 9))
            0: enc_str[$urandom_range(0, enc_str.size() - 1)] = 8'($urandom_range(0, 255));
            1: begin
                cut = $urandom_range(0, enc_str.size() - 1);
                repeat (cut) void'(enc_str.pop_back());
            end
            default: ;
        endcase
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            send_request(dir_rows[i]);
        end

        while (chars_taken < CHAR_TARGET) begin
            build_string();
            for (int k = 0; k < enc_str.size(); k++) begin
                send_request(pred_row(enc_str[k], k == enc_str.size() - 1));
            end
        end
        i_s_axis_tvalid <= 1'b0;

        // Drain: the watchdog bounds this wait.
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d characters (%0d outside dropped tails) in %0d strings,",
                 chars_taken, live_chars, strings_sent);
        $display("%0d results checked; errors: truncated escape %0d, bad hex %0d,",
                 results_seen, status_seen[ST_TRUNC_ESC], status_seen[ST_BAD_HEX]);
        $display("truncated utf8 %0d, missing percent %0d",
                 status_seen[ST_TRUNC_U8], status_seen[ST_NO_PCT]);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: changing stall patterns, plus two long hold-offs that let
    // the output buffer fill and back-pressure the input side.
    // ------------------------------------------------------------------
    int       hold_left    = 0;
    int       holds_done   = 0;
    int       rx_mode_left = 0;
    int       rx_tick      = 0;
    t_rx_mode rx_mode      = RX_OPEN;

    always @(posedge i_clk) begin
        rx_tick++;
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else if ((holds_done == 0 && chars_taken >= HOLD_AT_A) ||
                     (holds_done == 1 && chars_taken >= HOLD_AT_B)) begin
            holds_done++;
            hold_left = HOLD_CYCLES - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = t_rx_mode'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(16, 120);
            end else begin
                rx_mode_left--;
            end
            case (rx_mode)
                RX_OPEN:   i_m_axis_tready <= 1'b1;
                RX_COIN:   i_m_axis_tready <= ($urandom_range(0, 1) != 0);
                RX_SPARSE: i_m_axis_tready <= ($urandom_range(0, 3) == 0);
                default:   i_m_axis_tready <= (rx_tick % 5 != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result checker and watchdog
    // ------------------------------------------------------------------
    function automatic void log_fault(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endfunction

    t_dec_result act;
    t_dec_result want;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                act.data   = o_m_axis_tdata;
                act.has    = o_m_axis_tuser[0];
                act.status = t_status'(o_m_axis_tuser[3:1]);
                act.eos    = o_m_axis_tlast;
                if (decoded_q.size() == 0) begin
                    log_fault($sformatf("unexpected result: byte %02h has %0d status %0d last %0d",
                                        act.data, act.has, act.status, act.eos));
                end else begin
                    want = decoded_q.pop_front();
                    results_seen++;
                    status_seen[want.status]++;
                    if (act.data !== want.data || act.has !== want.has ||
                        act.status !== want.status || act.eos !== want.eos) begin
                        log_fault($sformatf({"result %0d mismatch: expected byte %02h has %0d ",
                                             "status %0d last %0d, got byte %02h has %0d ",
                                             "status %0d last %0d"},
                                            results_seen, want.data, want.has, want.status,
                                            want.eos, act.data, act.has, act.status, act.eos));
                    end
                end
            end
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("watchdog: no request moved for %0d cycles, %0d results pending",
                             quiet_cycles, decoded_q.size());
                    $display("Test completed with failures");
                    $finish;
                end
            end
        end
    end

endmodule

### sim.f
hdl/urlpd_pkg.sv
hdl/url_percent_decoder_utf8.sv
tb/url_percent_decoder_utf8_tb.sv
